// ===== design/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// shared types and codes for the indexed list store
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;
    localparam logic [OP_W-1:0] OP_SET    = 2'd3;

    typedef struct packed {
        logic            cmd_en;
        logic [OP_W-1:0] opcode;
        logic            rd_load;
        logic            rd_shift;
    } cell_cmd_t;

endpackage

// ===== design/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// one list slot: holds an entry and one stage of the read line
// ----------------------------------------------------------------------------
module ils_cell #(
    parameter int INDEX = 0,
    parameter int POS_W = 7
) (
    input  logic                           aclk,
    input  ils_pkg::cell_cmd_t             cmd,
    input  logic [POS_W-1:0]               position,
    input  logic signed [ils_pkg::DATA_W-1:0] value,
    input  logic signed [ils_pkg::DATA_W-1:0] lower_entry,
    input  logic signed [ils_pkg::DATA_W-1:0] upper_entry,
    input  logic signed [ils_pkg::DATA_W-1:0] upper_rd,
    output logic signed [ils_pkg::DATA_W-1:0] entry,
    output logic signed [ils_pkg::DATA_W-1:0] rd
);

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic signed [ils_pkg::DATA_W-1:0] entry_reg, entry_next;
    logic signed [ils_pkg::DATA_W-1:0] rd_reg, rd_next;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.cmd_en) begin
            case (cmd.opcode)
                ils_pkg::OP_INSERT: begin
                    if (IDX == position) begin
                        entry_next = value;
                    end else if (IDX > position) begin
                        entry_next = lower_entry;
                    end
                end
                ils_pkg::OP_ERASE: begin
                    if (IDX >= position) begin
                        entry_next = upper_entry;
                    end
                end
                ils_pkg::OP_SET: begin
                    if (IDX == position) begin
                        entry_next = value;
                    end
                end
                default: begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_comb begin
        rd_next = rd_reg;
        if (cmd.rd_load) begin
            rd_next = entry_reg;
        end else if (cmd.rd_shift) begin
            rd_next = upper_rd;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        rd_reg    <= rd_next;
    end

    assign entry = entry_reg;
    assign rd    = rd_reg;

endmodule

// ===== design/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store
// ordered list of signed 32-bit values held in a chain of cells
// ----------------------------------------------------------------------------
// Each slot of the list is a cell that can load its lower or upper neighbor,
// so insert, erase and set finish in the cycle the request is taken and, if
// the output is free, a new request follows in the next cycle. A get copies
// all entries into a read line that shifts one cell per cycle toward slot
// zero and holds off requests until its result is registered. Every request
// yields one result; an out-of-range position or an insert into a full list
// sets the error flag, reads zero and leaves the list unchanged.
module indexed_list_store #(
    parameter  int CAPACITY = 64,
    localparam int POS_W    = $clog2(CAPACITY + 1),
    localparam int IN_W     = ((ils_pkg::DATA_W + POS_W + 7) / 8) * 8,
    localparam int OUT_W    = ((ils_pkg::DATA_W + POS_W + 7) / 8) * 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // value, position
    input  logic [1:0]       s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [OUT_W-1:0] m_tdata,   // read_value, list_size
    output logic [0:0]       m_tuser    // error
);

    localparam logic [POS_W-1:0] CAP_L = POS_W'(CAPACITY);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SHIFT = 1'b1;

    logic                              state_reg, state_next;
    logic [POS_W-1:0]                  count_reg, count_next;
    logic [POS_W-1:0]                  shift_cnt_reg, shift_cnt_next;
    logic                              m_valid_reg, m_valid_next;
    logic signed [ils_pkg::DATA_W-1:0] out_data_reg, out_data_next;
    logic [POS_W-1:0]                  out_size_reg, out_size_next;
    logic                              out_err_reg, out_err_next;

    logic [ils_pkg::OP_W-1:0]          s_opcode;
    logic [POS_W-1:0]                  s_position;
    logic signed [ils_pkg::DATA_W-1:0] s_value;
    logic                              s_accept;
    logic                              out_free;
    logic                              req_err;
    ils_pkg::cell_cmd_t                cmd;

    logic signed [ils_pkg::DATA_W-1:0] entry_w [CAPACITY];
    logic signed [ils_pkg::DATA_W-1:0] rd_w    [CAPACITY];

    assign s_opcode   = s_tuser;
    assign s_position = s_tdata[ils_pkg::DATA_W +: POS_W];
    assign s_value    = s_tdata[ils_pkg::DATA_W-1:0];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_opcode == ils_pkg::OP_INSERT) begin
            req_err = (count_reg >= CAP_L) || (s_position > count_reg);
        end else begin
            req_err = (s_position >= count_reg);
        end
    end

    always_comb begin
        cmd.cmd_en   = s_accept && !req_err;
        cmd.opcode   = s_opcode;
        cmd.rd_load  = s_accept && !req_err && (s_opcode == ils_pkg::OP_GET);
        cmd.rd_shift = (state_reg == ST_SHIFT) && (shift_cnt_reg != '0);
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        shift_cnt_next = shift_cnt_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_size_next  = out_size_reg;
        out_err_next   = out_err_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (cmd.rd_load) begin
                        shift_cnt_next = s_position;
                        state_next     = ST_SHIFT;
                    end else begin
                        if (!req_err && s_opcode == ils_pkg::OP_INSERT) begin
                            count_next = count_reg + 1'b1;
                        end else if (!req_err && s_opcode == ils_pkg::OP_ERASE) begin
                            count_next = count_reg - 1'b1;
                        end
                        m_valid_next  = 1'b1;
                        out_data_next = '0;
                        out_size_next = count_next;
                        out_err_next  = req_err;
                    end
                end
            end
            ST_SHIFT: begin
                if (shift_cnt_reg != '0) begin
                    shift_cnt_next = shift_cnt_reg - 1'b1;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_data_next = rd_w[0];
                    out_size_next = count_reg;
                    out_err_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        shift_cnt_reg <= shift_cnt_next;
        out_data_reg  <= out_data_next;
        out_size_reg  <= out_size_next;
        out_err_reg   <= out_err_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [ils_pkg::DATA_W-1:0] lower_e, upper_e, upper_r;
            if (gi == 0) begin : g_first
                assign lower_e = '0;
            end else begin : g_mid_lo
                assign lower_e = entry_w[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign upper_e = '0;
                assign upper_r = '0;
            end else begin : g_mid_hi
                assign upper_e = entry_w[gi+1];
                assign upper_r = rd_w[gi+1];
            end
            ils_cell #(
                .INDEX (gi),
                .POS_W (POS_W)
            ) u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .position    (s_position),
                .value       (s_value),
                .lower_entry (lower_e),
                .upper_entry (upper_e),
                .upper_rd    (upper_r),
                .entry       (entry_w[gi]),
                .rd          (rd_w[gi])
            );
        end
    endgenerate

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({out_size_reg, out_data_reg});
    assign m_tuser  = out_err_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_L)
        else $error("entry count above capacity");

    a_shift_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> !s_tready)
        else $error("request taken during read shift");

    a_quick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (req_err || s_opcode != ils_pkg::OP_GET)) |=> m_valid_reg)
        else $error("missing result after request");

    a_error_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_err_reg) |-> (out_data_reg == '0))
        else $error("error result with nonzero read value");

endmodule
